### hw/rtl/aesd_pkg.sv
package aesd_pkg;

  typedef struct packed {
    logic [63:0] ct_high;
    logic [63:0] ct_low;
  } aesd_in_t;

  typedef struct packed {
    logic [63:0] pt_high;
    logic [63:0] pt_low;
  } aesd_out_t;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  localparam int NUM_ROUNDS = 10;

  // settle count: runs down after a key write or reset until the last round key is rebuilt
  localparam logic [3:0] KEY_SETTLE = 4'd11;

  localparam logic [7:0] RCON [0:9] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                        8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  localparam logic [7:0] FWD_BOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] INV_BOX [0:255] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte i sits at bits 127-8i
  function automatic logic [7:0] st_byte(input logic [127:0] s, input int i);
    st_byte = s[127 - 8*i -: 8];
  endfunction

  // inverse row shift then inverse s-box
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c+r) -: 8] = INV_BOX[st_byte(s, 4*((c - r + 4) % 4) + r)];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = st_byte(s, 4*c + k);
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        m9[k] = x8[k] ^ a[k];
        mb[k] = x8[k] ^ x2[k] ^ a[k];
        md[k] = x8[k] ^ x4[k] ^ a[k];
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      t[127 - 8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[127 - 8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[127 - 8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[127 - 8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    inv_mix = t;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
    t = {FWD_BOX[w[3][23:16]] ^ rc, FWD_BOX[w[3][15:8]], FWD_BOX[w[3][7:0]],
         FWD_BOX[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    next_rkey = {w[0], w[1], w[2], w[3]};
  endfunction

endpackage

### hw/rtl/aes128_block_decrypt.sv
// aes-128 block decryption, one 128-bit block per transfer
//
// input channel: in_valid / in_stall / in_data (ct_high, ct_low)
// output channel: out_valid / out_stall / out_data (pt_high, pt_low)
// a transfer happens on a rising edge with valid high and stall low
// config: cfg_we / cfg_idx / cfg_data; index 0 key_high, 1 key_low
//
// pipeline: one entry stage (add round key 10 plus inverse shift/sub),
// nine round stages (add key, inv mix, inverse shift/sub) and a final
// add-key stage; eleven registers, so a result passes the entry register,
// the nine round registers and the final one before it can leave
// throughput: one block per cycle unless output or a key rebuild stalls
// the whole pipe advances when the output register is empty or taken;
// in_stall follows from that, so a stall freezes every stage, nothing lost
// round keys are rebuilt one stage per cycle after a key write or reset;
// in_stall stays high until the last round key is rebuilt
// reset clears all valid bits and both key registers
module aes128_block_decrypt
  import aesd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  aesd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output aesd_out_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_idx,
  input  logic [63:0] cfg_data
);

  logic [127:0] rkey [0:10];
  logic         keys_ready;
  logic         adv;
  logic         vld [0:11];
  logic [127:0] st  [0:11];
  logic         vld1_r;
  logic [127:0] st1_r;

  aesd_key_sched u_keys (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_idx), .cfg_data, .rkey, .keys_ready
  );

  // pipe moves when the last stage is empty or being taken
  assign adv      = !vld[11] || !out_stall;
  // hold off new blocks until the round keys match the key registers
  assign in_stall = !adv || !keys_ready;

  // entry: initial key add then inverse shift/sub
  assign vld[0] = in_valid && keys_ready;
  assign st[0]  = inv_shift_sub({in_data.ct_high, in_data.ct_low} ^ rkey[10]);

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (adv) vld1_r <= vld[0];
  end

  always_ff @(posedge clk) begin
    if (adv) st1_r <= st[0];
  end

  assign vld[1] = vld1_r;
  assign st[1]  = st1_r;

  // rounds 9 down to 1, then the final key add with round key 0
  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
    aesd_round u_rnd (
      .clk, .rst_n, .adv,
      .last    (g == NUM_ROUNDS),
      .vld_in  (vld[g]),
      .st_in   (st[g]),
      .rkey    (rkey[NUM_ROUNDS - g]),
      .vld_out (vld[g+1]),
      .st_out  (st[g+1])
    );
  end

  assign out_valid        = vld[11];
  assign out_data.pt_high = st[11][127:64];
  assign out_data.pt_low  = st[11][63:0];

endmodule

### hw/rtl/aesd_key_sched.sv
module aesd_key_sched
  import aesd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_idx,
  input  logic [63:0]  cfg_data,
  output logic [127:0] rkey [0:10],
  output logic         keys_ready
);

  logic [63:0]  key_high_r;
  logic [63:0]  key_low_r;
  logic [127:0] rk_r [0:10];
  logic [3:0]   settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one round key per cycle; settles after a key write once the change reaches rk_r[10]
  always_ff @(posedge clk) begin
    rk_r[0] <= {key_high_r, key_low_r};
    for (int i = 1; i <= NUM_ROUNDS; i++) rk_r[i] <= next_rkey(rk_r[i-1], RCON[i-1]);
  end

  // counts down while the round key chain refills
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) settle_r <= KEY_SETTLE;
    else if (settle_r != 4'd0) settle_r <= settle_r - 4'd1;
  end

  assign rkey       = rk_r;
  assign keys_ready = (settle_r == 4'd0);

endmodule

### hw/rtl/aesd_round.sv
module aesd_round
  import aesd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         last,
  input  logic         vld_in,
  input  logic [127:0] st_in,
  input  logic [127:0] rkey,
  output logic         vld_out,
  output logic [127:0] st_out
);

  logic         vld_r;
  logic [127:0] st_r;
  logic [127:0] st_nxt;

  always_comb begin
    if (last) st_nxt = st_in ^ rkey;
    else      st_nxt = inv_shift_sub(inv_mix(st_in ^ rkey));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv) vld_r <= vld_in;
  end

  always_ff @(posedge clk) begin
    if (adv) st_r <= st_nxt;
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;

endmodule

### hw/rtl/aesd_checker.sv
module aesd_checker
  import aesd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  aesd_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  aesd_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a blocked output backs up into the input
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input not stalled under output backpressure");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // a stalled input block waits unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

endmodule

bind aes128_block_decrypt aesd_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
